>>> src/sba_pkg.sv
package sba_pkg;

	localparam int unsigned AddrWidth   = 32;
	localparam int unsigned HostWidth   = 30;
	localparam int unsigned PrefixWidth = 5;
	localparam int unsigned Log2Width   = 5;
	localparam int unsigned QueueDepth  = 4;
	localparam int unsigned QueuePtrW   = $clog2(QueueDepth);

	localparam logic [AddrWidth-1:0] BaseReset = 32'd201326592;

	// One classified request on its way from the front to the back.
	typedef struct packed {
		logic [Log2Width-1:0] size_log2;
	} sba_req_t;

endpackage

>>> src/sba_front.sv
module sba_front (
	input  logic [sba_pkg::HostWidth-1:0] host_count,
	output sba_pkg::sba_req_t             req
);
	import sba_pkg::*;

	logic [HostWidth:0]   need;
	logic [Log2Width-1:0] top_bit;

	// Block log2 is one above the leading one of host_count + 2.
	assign need = {1'b0, host_count} + (HostWidth+1)'(2);

	always_comb begin
		top_bit = '0;
		for (int i = 0; i <= HostWidth; i++) begin
			if (need[i]) begin
				top_bit = Log2Width'(i);
			end
		end
	end

	assign req.size_log2 = top_bit + Log2Width'(1);

endmodule

>>> src/sba_queue.sv
module sba_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sba_pkg::sba_req_t push_req,
	output logic              full,
	input  logic              pop,
	output sba_pkg::sba_req_t pop_req,
	output logic              empty
);
	import sba_pkg::*;

	sba_req_t             slot_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueuePtrW:0]   count_q;

	assign full    = (count_q == (QueuePtrW+1)'(QueueDepth));
	assign empty   = (count_q == '0);
	assign pop_req = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QueuePtrW+1)'(1);
				2'b01:   count_q <= count_q - (QueuePtrW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/sba_back.sv
module sba_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            base_address_wen,
	input  logic [sba_pkg::AddrWidth-1:0]   base_address,
	input  logic                            req_valid,
	input  sba_pkg::sba_req_t               req,
	output logic                            req_take,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sba_pkg::AddrWidth-1:0]   network_address,
	output logic [sba_pkg::PrefixWidth-1:0] prefix_length,
	output logic [sba_pkg::AddrWidth-1:0]   first_host,
	output logic [sba_pkg::AddrWidth-1:0]   last_host,
	output logic [sba_pkg::AddrWidth-1:0]   broadcast_address,
	output logic                            exhausted
);
	import sba_pkg::*;

	logic [AddrWidth:0]   next_free_q;
	logic [AddrWidth:0]   size_mask;
	logic [AddrWidth:0]   rounded;
	logic [AddrWidth:0]   aligned;
	logic [AddrWidth:0]   bcast;
	logic                 no_room;
	logic                 out_valid_q;

	// Block sizes divide 2^32, so an aligned start below 2^32 always fits.
	assign size_mask = ((AddrWidth+1)'(1) << req.size_log2) - (AddrWidth+1)'(1);
	assign rounded   = next_free_q + size_mask;
	assign aligned   = rounded & ~size_mask;
	assign bcast     = aligned | size_mask;
	assign no_room   = aligned[AddrWidth];

	assign req_take  = req_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			next_free_q <= {1'b0, BaseReset};
		end else begin
			if (req_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (base_address_wen) begin
				next_free_q <= {1'b0, base_address};
			end else if (req_take && !no_room) begin
				next_free_q <= bcast + (AddrWidth+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			exhausted <= no_room;
			if (no_room) begin
				network_address   <= '0;
				prefix_length     <= '0;
				first_host        <= '0;
				last_host         <= '0;
				broadcast_address <= '0;
			end else begin
				network_address   <= aligned[AddrWidth-1:0];
				prefix_length     <= PrefixWidth'(6'd32 - {1'b0, req.size_log2});
				first_host        <= aligned[AddrWidth-1:0] | AddrWidth'(1);
				last_host         <= bcast[AddrWidth-1:0] & ~AddrWidth'(1);
				broadcast_address <= bcast[AddrWidth-1:0];
			end
		end
	end

endmodule

>>> src/subnet_block_allocator.sv
// Subnet block allocator: each item asks for a subnet holding host_count hosts and
// receives one result item with the network address, prefix length, first and last
// host and broadcast address of a power-of-two block, the smallest strictly larger
// than host_count + 2. Blocks are handed out upward from a running next-free
// address, each aligned to its own size over the full 32-bit space; a request that
// would run past 255.255.255.255 returns exhausted = 1 with all other fields zero
// and allocates nothing. Writing base_address restarts allocation at that address;
// write it only while no item is in flight. One item is taken per cycle while the
// queue is not full: the front finds the block size with a leading-one detect, a
// four-entry queue separates it from the back, and the back does the round-up and
// advance against next_free combinationally and registers the result, holding it
// until the output side is ready.
module subnet_block_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            base_address_wen,
	input  logic [sba_pkg::AddrWidth-1:0]   base_address,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sba_pkg::HostWidth-1:0]   host_count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sba_pkg::AddrWidth-1:0]   network_address,
	output logic [sba_pkg::PrefixWidth-1:0] prefix_length,
	output logic [sba_pkg::AddrWidth-1:0]   first_host,
	output logic [sba_pkg::AddrWidth-1:0]   last_host,
	output logic [sba_pkg::AddrWidth-1:0]   broadcast_address,
	output logic                            exhausted
);
	import sba_pkg::*;

	sba_req_t in_req;
	sba_req_t q_req;
	logic     q_full;
	logic     q_empty;
	logic     q_pop;

	// Classify the incoming item: block size only, no state needed.
	sba_front u_front (
		.host_count (host_count),
		.req        (in_req)
	);

	// Hold classified items until the back can take them.
	assign in_ready = !q_full;

	sba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && !q_full),
		.push_req (in_req),
		.full     (q_full),
		.pop      (q_pop),
		.pop_req  (q_req),
		.empty    (q_empty)
	);

	// Allocate against next_free and present the result.
	sba_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.base_address_wen  (base_address_wen),
		.base_address      (base_address),
		.req_valid         (!q_empty),
		.req               (q_req),
		.req_take          (q_pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.network_address   (network_address),
		.prefix_length     (prefix_length),
		.first_host        (first_host),
		.last_host         (last_host),
		.broadcast_address (broadcast_address),
		.exhausted         (exhausted)
	);

endmodule
